// ----- design/pap_pkg.sv -----
// Shared constants and the sequencer state type for the polygon area and perimeter block.
`default_nettype none

package pap_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int AREA_BITS      = 42;
	localparam int LEN_BITS       = 35;
	localparam int OUT_DATA_W     = ((AREA_BITS + LEN_BITS + 7) / 8) * 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_CROSS,
		ST_MUL_DX,
		ST_MUL_DY,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_LEN,
		ST_NEXT,
		ST_EMIT
	} pap_state_t;

endpackage

`default_nettype wire

// ----- design/pap_isqrt.sv -----
// Iterative bitwise integer square root with fraction bits, one root bit per cycle.
`default_nettype none

module pap_isqrt #(
	parameter int PAIRS = pap_pkg::COORD_BITS_DEF + 1,
	parameter int FRAC  = pap_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2*PAIRS-1:0]      radicand,
	output logic                    done,
	output logic [PAIRS+FRAC-1:0]   root
);

	localparam int ROOT_W = PAIRS + FRAC;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [2*PAIRS-1:0] rad_q;
	logic [ROOT_W+1:0]  rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [ROOT_W+3:0]  trial;
	logic [ROOT_W+3:0]  sub;
	logic               ge;
	logic [ROOT_W+3:0]  diff;

	assign trial = {rem_q, rad_q[2*PAIRS-1 -: 2]};
	assign sub   = {2'b00, root_q, 2'b01};
	assign ge    = trial >= sub;
	assign diff  = ge ? (trial - sub) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*PAIRS-3:0], 2'b00};
			rem_q  <= diff[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ----- design/polygon_area_perimeter.sv -----
// Top level: streaming shoelace area and perimeter of a polygon with one shared multiplier.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_valid/cfg_ready  cfg_data = closed_chain
//   s        in   s_tvalid/s_tready    s_tdata = x_coord, y_coord; s_tlast = last_point
//   m        out  m_tvalid/m_tready    m_tdata = area_doubled, perimeter_q8; m_tuser = saturated
//
// A first vertex that is not also the last is only stored. Every later vertex runs a
// segment whose length comes from the square root unit, which produces one root bit per
// cycle. A last vertex adds a closing segment, whose length is taken only while closed_chain is 1.
// Reset clears the polygon sums and sets closed_chain to 1.
// A finished polygon waits in the emit step while the previous result is still not taken.
`default_nettype none

module polygon_area_perimeter #(
	parameter int COORD_BITS = pap_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pap_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,   // x_coord, y_coord
	input  logic                                s_tlast,   // last_point
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pap_pkg::OUT_DATA_W-1:0]      m_tdata,   // area_doubled, perimeter_q8
	output logic                                m_tuser    // saturated
);

	localparam int AREA_BITS = pap_pkg::AREA_BITS;
	localparam int LEN_BITS  = pap_pkg::LEN_BITS;
	localparam int PAIRS     = COORD_BITS + 1;
	localparam int ROOT_W    = PAIRS + FRAC_BITS;
	localparam int PROD_W    = 2 * PAIRS;
	localparam int CROSS_W   = ((AREA_BITS + 1 > PROD_W) ? AREA_BITS + 1 : PROD_W) + 2;
	localparam int LSUM_W    = ((LEN_BITS > ROOT_W) ? LEN_BITS : ROOT_W) + 1;

	localparam logic signed [CROSS_W-1:0] CROSS_LIM =
		{{(CROSS_W-AREA_BITS){1'b0}}, {AREA_BITS{1'b1}}};
	localparam logic signed [CROSS_W-1:0] CROSS_NLIM = -CROSS_LIM;

	pap_pkg::pap_state_t state_q, state_d;

	logic                          closed_q;
	logic                          have_first_q;
	logic                          last_q;
	logic                          close_q;
	logic                          do_len_q;
	logic signed [COORD_BITS-1:0]  first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0]  ax_q, ay_q, bx_q, by_q;
	logic signed [COORD_BITS:0]    dx_q, dy_q;
	logic signed [CROSS_W-1:0]     term_q;
	logic [PROD_W-1:0]             sq_q;
	logic signed [AREA_BITS:0]     cross_q;
	logic [LEN_BITS-1:0]           len_q;
	logic                          ovf_q;
	logic                          m_tvalid_q;
	logic [AREA_BITS-1:0]          area_q;
	logic [LEN_BITS-1:0]           perim_q;
	logic                          sat_q;

	logic signed [COORD_BITS-1:0]  in_x, in_y;
	logic                          accept;
	logic                          out_free;
	logic                          out_load;
	logic                          root_start;
	logic                          root_done;
	logic [ROOT_W-1:0]             root;
	logic signed [COORD_BITS:0]    mul_a, mul_b;
	logic signed [PROD_W-1:0]      mul_p;
	logic signed [CROSS_W-1:0]     cross_sum;
	logic signed [AREA_BITS:0]     cross_clamped;
	logic                          cross_ovf;
	logic [LSUM_W-1:0]             len_sum;
	logic [LEN_BITS-1:0]           len_clamped;
	logic                          len_ovf;
	logic signed [AREA_BITS:0]     cross_neg;
	logic [AREA_BITS-1:0]          area_mag;

	assign in_x     = s_tdata[COORD_BITS-1:0];
	assign in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		s_tready   = (state_q == pap_pkg::ST_IDLE);
		root_start = (state_q == pap_pkg::ST_ROOT_GO);
		out_load   = (state_q == pap_pkg::ST_EMIT) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pap_pkg::ST_IDLE: begin
				if (accept && (have_first_q || s_tlast)) state_d = pap_pkg::ST_MUL_A;
			end
			pap_pkg::ST_MUL_A:  state_d = pap_pkg::ST_MUL_B;
			pap_pkg::ST_MUL_B:  state_d = pap_pkg::ST_CROSS;
			pap_pkg::ST_CROSS:  state_d = do_len_q ? pap_pkg::ST_MUL_DX : pap_pkg::ST_NEXT;
			pap_pkg::ST_MUL_DX: state_d = pap_pkg::ST_MUL_DY;
			pap_pkg::ST_MUL_DY: state_d = pap_pkg::ST_ROOT_GO;
			pap_pkg::ST_ROOT_GO: state_d = pap_pkg::ST_ROOT_WAIT;
			pap_pkg::ST_ROOT_WAIT: begin
				if (root_done) state_d = pap_pkg::ST_LEN;
			end
			pap_pkg::ST_LEN:    state_d = pap_pkg::ST_NEXT;
			pap_pkg::ST_NEXT: begin
				if (close_q)     state_d = pap_pkg::ST_EMIT;
				else if (last_q) state_d = pap_pkg::ST_MUL_A;
				else             state_d = pap_pkg::ST_IDLE;
			end
			pap_pkg::ST_EMIT: begin
				if (out_free) state_d = pap_pkg::ST_IDLE;
			end
			default: state_d = pap_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			pap_pkg::ST_MUL_A: begin
				mul_a = {ax_q[COORD_BITS-1], ax_q};
				mul_b = {by_q[COORD_BITS-1], by_q};
			end
			pap_pkg::ST_MUL_B: begin
				mul_a = {bx_q[COORD_BITS-1], bx_q};
				mul_b = {ay_q[COORD_BITS-1], ay_q};
			end
			pap_pkg::ST_MUL_DX: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			pap_pkg::ST_MUL_DY: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign cross_sum = CROSS_W'(cross_q) + term_q;

	always_comb begin
		cross_ovf     = 1'b0;
		cross_clamped = cross_sum[AREA_BITS:0];
		if (cross_sum > CROSS_LIM) begin
			cross_clamped = CROSS_LIM[AREA_BITS:0];
			cross_ovf     = 1'b1;
		end else if (cross_sum < CROSS_NLIM) begin
			cross_clamped = CROSS_NLIM[AREA_BITS:0];
			cross_ovf     = 1'b1;
		end
	end

	assign len_sum = LSUM_W'(len_q) + LSUM_W'(root);

	always_comb begin
		len_ovf     = (len_sum[LSUM_W-1:LEN_BITS] != '0);
		len_clamped = len_ovf ? {LEN_BITS{1'b1}} : len_sum[LEN_BITS-1:0];
	end

	assign cross_neg = -cross_q;
	assign area_mag  = cross_q[AREA_BITS] ? cross_neg[AREA_BITS-1:0] : cross_q[AREA_BITS-1:0];

	pap_isqrt #(
		.PAIRS (PAIRS),
		.FRAC  (FRAC_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_q),
		.done     (root_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pap_pkg::ST_IDLE;
			closed_q     <= 1'b1;
			have_first_q <= 1'b0;
			cross_q      <= '0;
			len_q        <= '0;
			ovf_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) closed_q <= cfg_data;
			if (accept) have_first_q <= 1'b1;
			if (state_q == pap_pkg::ST_CROSS) begin
				cross_q <= cross_clamped;
				if (cross_ovf) ovf_q <= 1'b1;
			end
			if (state_q == pap_pkg::ST_LEN) begin
				len_q <= len_clamped;
				if (len_ovf) ovf_q <= 1'b1;
			end
			if (out_load) begin
				cross_q      <= '0;
				len_q        <= '0;
				ovf_q        <= 1'b0;
				have_first_q <= 1'b0;
				m_tvalid_q   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pap_pkg::ST_IDLE: begin
				if (accept) begin
					last_q   <= s_tlast;
					prev_x_q <= in_x;
					prev_y_q <= in_y;
					bx_q     <= in_x;
					by_q     <= in_y;
					if (!have_first_q) begin
						first_x_q <= in_x;
						first_y_q <= in_y;
						ax_q      <= in_x;
						ay_q      <= in_y;
						close_q   <= 1'b1;
						do_len_q  <= closed_q;
					end else begin
						ax_q     <= prev_x_q;
						ay_q     <= prev_y_q;
						close_q  <= 1'b0;
						do_len_q <= 1'b1;
					end
				end
			end
			pap_pkg::ST_MUL_A: begin
				term_q <= CROSS_W'(mul_p);
				dx_q   <= {bx_q[COORD_BITS-1], bx_q} - {ax_q[COORD_BITS-1], ax_q};
			end
			pap_pkg::ST_MUL_B: begin
				term_q <= term_q - CROSS_W'(mul_p);
				dy_q   <= {by_q[COORD_BITS-1], by_q} - {ay_q[COORD_BITS-1], ay_q};
			end
			pap_pkg::ST_MUL_DX: sq_q <= $unsigned(mul_p);
			pap_pkg::ST_MUL_DY: sq_q <= sq_q + $unsigned(mul_p);
			pap_pkg::ST_NEXT: begin
				if (!close_q && last_q) begin
					ax_q     <= bx_q;
					ay_q     <= by_q;
					bx_q     <= first_x_q;
					by_q     <= first_y_q;
					close_q  <= 1'b1;
					do_len_q <= closed_q;
				end
			end
			pap_pkg::ST_EMIT: begin
				if (out_free) begin
					area_q  <= area_mag;
					perim_q <= len_q;
					sat_q   <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(pap_pkg::OUT_DATA_W-AREA_BITS-LEN_BITS){1'b0}}, perim_q, area_q};
	assign m_tuser   = sat_q;

	// The root unit only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == pap_pkg::ST_ROOT_WAIT)
		else $error("square root finished outside its wait step");

	// A loaded result is presented and the sequencer is free again.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid && state_q == pap_pkg::ST_IDLE)
		else $error("result load did not present a transfer");

	// The clamped cross sum never reaches the one value whose magnitude does not fit.
	assert property (@(posedge clk) disable iff (!arst_n)
		cross_q != {1'b1, {AREA_BITS{1'b0}}})
		else $error("cross sum escaped its clamp");

	// A vertex after the first always starts a segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && have_first_q |=> state_q == pap_pkg::ST_MUL_A)
		else $error("segment not started after a vertex");

endmodule

`default_nettype wire

// ----- tb/polygon_area_perimeter_tb.sv -----
// Self-checking testbench that streams polygons into polygon_area_perimeter and checks area and perimeter.

typedef struct {
	logic [pap_pkg::AREA_BITS-1:0] area;
	logic [pap_pkg::LEN_BITS-1:0]  perim;
	logic                          sat;
} poly_totals_t;

localparam longint          AreaLimit  = (64'sd1 << pap_pkg::AREA_BITS) - 1;
localparam longint unsigned PerimLimit = (64'd1 << pap_pkg::LEN_BITS) - 1;

class pap_scoreboard;
	bit closed_chain = 1'b1;
	longint first_x, first_y, prev_x, prev_y;
	longint area_acc;
	longint unsigned perim_acc;
	bit have_first, clipped;
	poly_totals_t pending_totals[$];
	int failures, reported;

	function void clear_polygon();
		first_x = 0;
		first_y = 0;
		prev_x = 0;
		prev_y = 0;
		area_acc = 0;
		perim_acc = 0;
		have_first = 1'b0;
		clipped = 1'b0;
	endfunction

	// Largest root whose square does not exceed the scaled squared distance.
	function longint unsigned segment_q8(longint ax, longint ay, longint bx, longint by);
		longint dx, dy;
		longint unsigned target, root, trial;
		dx = bx - ax;
		dy = by - ay;
		target = (dx * dx + dy * dy) << (2 * pap_pkg::FRAC_BITS_DEF);
		root = 0;
		for (int b = 27; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= target)
				root = trial;
		end
		return root;
	endfunction

	function void add_edge(longint ax, longint ay, longint bx, longint by, bit with_length);
		longint sum;
		longint unsigned len;
		sum = area_acc + (ax * by - bx * ay);
		if (sum > AreaLimit) begin
			sum = AreaLimit;
			clipped = 1'b1;
		end
		if (sum < -AreaLimit) begin
			sum = -AreaLimit;
			clipped = 1'b1;
		end
		area_acc = sum;
		if (with_length) begin
			len = perim_acc + segment_q8(ax, ay, bx, by);
			if (len > PerimLimit) begin
				len = PerimLimit;
				clipped = 1'b1;
			end
			perim_acc = len;
		end
	endfunction

	function void add_vertex(logic signed [pap_pkg::COORD_BITS_DEF-1:0] x,
			logic signed [pap_pkg::COORD_BITS_DEF-1:0] y, bit last);
		longint cx, cy;
		longint mag;
		poly_totals_t t;
		cx = longint'(x);
		cy = longint'(y);
		if (!have_first) begin
			first_x = cx;
			first_y = cy;
			have_first = 1'b1;
		end else begin
			add_edge(prev_x, prev_y, cx, cy, 1'b1);
		end
		prev_x = cx;
		prev_y = cy;
		if (last) begin
			add_edge(cx, cy, first_x, first_y, closed_chain);
			mag = (area_acc < 0) ? -area_acc : area_acc;
			t.area = mag[pap_pkg::AREA_BITS-1:0];
			t.perim = perim_acc[pap_pkg::LEN_BITS-1:0];
			t.sat = clipped;
			pending_totals = {pending_totals, t};
			clear_polygon();
		end
	endfunction

	function void check_totals(logic [pap_pkg::AREA_BITS-1:0] area,
			logic [pap_pkg::LEN_BITS-1:0] perim, logic sat);
		poly_totals_t t;
		if (pending_totals.size() == 0) begin
			failures++;
			if (reported < 10) begin
				reported++;
				$display("unexpected result: area %0d perimeter %0d saturated %0d",
					area, perim, sat);
			end
			return;
		end
		t = pending_totals.pop_front();
		if (area !== t.area || perim !== t.perim || sat !== t.sat) begin
			failures++;
			if (reported < 10) begin
				reported++;
				$display("mismatch: expected area %0d perimeter %0d saturated %0d,",
					t.area, t.perim, t.sat);
				$display("          got area %0d perimeter %0d saturated %0d",
					area, perim, sat);
			end
		end
	endfunction

	function int pending();
		return pending_totals.size();
	endfunction
endclass

module polygon_area_perimeter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = pap_pkg::COORD_BITS_DEF;
	typedef logic signed [CW-1:0] coord_t;
	localparam coord_t CMIN = 16'sh8000;
	localparam coord_t CMAX = 16'sh7FFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b1;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [((2*CW+7)/8)*8-1:0] s_tdata = '0;   // x_coord, y_coord
	logic s_tlast = 1'b0;                       // last_point
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [pap_pkg::OUT_DATA_W-1:0] m_tdata;    // area_doubled, perimeter_q8
	logic m_tuser;                              // saturated

	bit src_jitter = 1'b1;
	bit sink_jitter = 1'b1;
	int hold_left = 0;
	pap_scoreboard board = new;

	polygon_area_perimeter #(
		.COORD_BITS(CW),
		.FRAC_BITS(pap_pkg::FRAC_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else begin
			m_tready = !(sink_jitter && $urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_totals(m_tdata[pap_pkg::AREA_BITS-1:0],
				m_tdata[pap_pkg::AREA_BITS+pap_pkg::LEN_BITS-1:pap_pkg::AREA_BITS], m_tuser);
	end

	initial begin
		#8_000_000;
		$display("polygon_area_perimeter verification failed");
		$finish;
	end

	function coord_t pick_coord();
		case ($urandom_range(9))
			0: pick_coord = CMAX;
			1: pick_coord = CMIN;
			2: pick_coord = coord_t'($urandom_range(3)) - 16'sd1;
			3, 4, 5: pick_coord = coord_t'($urandom_range(100)) - 16'sd50;
			default: pick_coord = coord_t'($urandom);
		endcase
	endfunction

	task automatic send_vertex(coord_t x, coord_t y, bit last);
		if (src_jitter) begin
			while ($urandom_range(99) < 8) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				s_tdata = $urandom;
				s_tlast = 1'($urandom_range(1));
			end
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {y, x};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		board.add_vertex(x, y, last);
	endtask

	task automatic write_closed(bit v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		board.closed_chain = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tdata = $urandom;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic hold_sink(int cycles);
		@(posedge clk);
		hold_left = cycles;
	endtask

	// Full-range square walked lap after lap, so both sums grow far beyond a single lap.
	task automatic square_laps(int laps, bit reverse);
		int idx;
		for (int k = 0; k < 4 * laps; k++) begin
			idx = reverse ? 3 - (k % 4) : k % 4;
			send_vertex((idx == 1 || idx == 2) ? CMAX : CMIN, (idx >= 2) ? CMAX : CMIN,
				k == 4 * laps - 1);
		end
	endtask

	task automatic random_phase(int items);
		int count, n;
		count = 0;
		while (count < items) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_vertex(pick_coord(), pick_coord(), i == n - 1);
			count += n;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_closed(1'b1);
		send_vertex(16'sd0, 16'sd0, 1'b1);
		send_vertex(CMAX, CMIN, 1'b1);
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd3, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd4, 1'b1);
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd4, 1'b0);
		send_vertex(16'sd3, 16'sd0, 1'b1);
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd1, 16'sd1, 1'b1);
		send_vertex(CMIN, CMIN, 1'b0);
		send_vertex(CMAX, CMIN, 1'b0);
		send_vertex(CMAX, CMAX, 1'b0);
		send_vertex(CMIN, CMAX, 1'b1);
		wait_drained();

		write_closed(1'b0);
		send_vertex(CMIN, CMAX, 1'b0);
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(CMAX, CMIN, 1'b1);
		send_vertex(CMIN, 16'sd0, 1'b0);
		send_vertex(CMAX, CMAX, 1'b0);
		send_vertex(16'sd0, CMIN, 1'b1);
		send_vertex(-16'sd1, -16'sd1, 1'b1);
		wait_drained();

		write_closed(1'b1);
		square_laps(25, 1'b0);
		wait_drained();
		write_closed(1'b0);
		square_laps(25, 1'b1);
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			write_closed(p == 0 ? 1'b1 : p == 1 ? 1'b0 : 1'($urandom_range(1)));
			src_jitter = (p != 2);
			sink_jitter = (p != 2);
			// The receiver stalls long enough for the block to back up its input.
			if (p == 1)
				hold_sink(3000);
			random_phase(70);
			if (p == 3)
				wait_drained();
			random_phase(70);
			wait_drained();
		end

		if (board.failures == 0 && board.pending() == 0) begin
			$display("polygon_area_perimeter verification clean");
		end else begin
			$display("polygon_area_perimeter verification failed");
		end
		$finish;
	end
endmodule

// ----- polygon_area_perimeter.f -----
design/pap_pkg.sv
design/pap_isqrt.sv
design/polygon_area_perimeter.sv
tb/polygon_area_perimeter_tb.sv
